>>> design/lif_pkg.sv
// ----------------------------------------------------------------------------
// LIF neuron package
// Shared widths, register indexes and hash constants for the leaky
// integrate-and-fire neuron update pipeline.
// ----------------------------------------------------------------------------
package lif_pkg;

  localparam int unsigned IDX_W    = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned DECAY_W  = 17;
  localparam int unsigned NOISE_W  = 31;
  localparam int unsigned CFG_IDX_W = 3;

  // Neurons at or above this index do not exist and pass through unchanged.
  localparam int unsigned MAX_NEURONS = 65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESETV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 3'd4;

  // Register reset values.
  localparam logic [DECAY_W-1:0] DECAY_RST  = 17'd65536;
  localparam logic [DATA_W-1:0]  THRESH_RST = 32'd65536;
  localparam logic [DATA_W-1:0]  RESETV_RST = 32'd0;
  localparam logic [NOISE_W-1:0] NOISE_RST  = 31'd0;
  localparam logic [DATA_W-1:0]  SEED_RST   = 32'd0;

  // Noise hash multipliers.
  localparam logic [DATA_W-1:0] HASH_STEP_MUL = 32'd2654435761;
  localparam logic [DATA_W-1:0] HASH_SEED_MUL = 32'd1664525;
  localparam logic [DATA_W-1:0] HASH_MIX_MUL  = 32'h045d9f3b;

endpackage

>>> design/lif_neuron_update.sv
// ----------------------------------------------------------------------------
// LIF neuron update
// Leaky integrate-and-fire membrane update with hashed uniform noise,
// threshold spike detection and saturation, in a four-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries one neuron per transfer:
//   index, membrane voltage, synaptic current, stimulus and time step. The
//   output channel (out_valid / out_ready) returns one result per input in
//   the same order: the index, the new voltage and the spike flag.
//   A result is registered in every stage in turn before out_valid rises;
//   throughput is one neuron per cycle while the receiver takes results.
//   The stages are: product and seed hash, hash mix multiply with the decay
//   sum, noise multiply, then final add, compare and saturate into the
//   output register.
//   Each stage holds its own valid bit and advances when the stage after it
//   is empty or moving, so a stalled receiver fills the pipeline and then
//   drops in_ready; nothing is lost or repeated.
//   Reset empties the pipeline and loads the register defaults. The cfg_
//   port writes one register per cycle with cfg_we; the user must change
//   registers only while no neuron is in flight (not enforced by the block).
// ----------------------------------------------------------------------------
module lif_neuron_update (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [lif_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lif_pkg::DATA_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lif_pkg::IDX_W-1:0]            in_neuron_index,
  input  logic signed [lif_pkg::DATA_W-1:0]    in_membrane_voltage,
  input  logic signed [lif_pkg::DATA_W-1:0]    in_synaptic_current,
  input  logic signed [lif_pkg::DATA_W-1:0]    in_stimulus_current,
  input  logic [lif_pkg::DATA_W-1:0]           in_time_step,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lif_pkg::IDX_W-1:0]            out_neuron_index,
  output logic signed [lif_pkg::DATA_W-1:0]    out_new_voltage,
  output logic                                 out_fired
);

  // Configuration registers.
  logic [lif_pkg::DECAY_W-1:0] decay_r;
  logic [lif_pkg::DATA_W-1:0]  thresh_r;
  logic [lif_pkg::DATA_W-1:0]  resetv_r;
  logic [lif_pkg::NOISE_W-1:0] noise_r;
  logic [lif_pkg::DATA_W-1:0]  seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= lif_pkg::DECAY_RST;
      thresh_r <= lif_pkg::THRESH_RST;
      resetv_r <= lif_pkg::RESETV_RST;
      noise_r  <= lif_pkg::NOISE_RST;
      seed_r   <= lif_pkg::SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lif_pkg::REG_DECAY:  decay_r  <= cfg_data[lif_pkg::DECAY_W-1:0];
        lif_pkg::REG_THRESH: thresh_r <= cfg_data;
        lif_pkg::REG_RESETV: resetv_r <= cfg_data;
        lif_pkg::REG_NOISE:  noise_r  <= cfg_data[lif_pkg::NOISE_W-1:0];
        lif_pkg::REG_SEED:   seed_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  assign s4_rdy   = !s4_vld_r || out_ready;
  assign s3_rdy   = !s3_vld_r || s4_rdy;
  assign s2_rdy   = !s2_vld_r || s3_rdy;
  assign s1_rdy   = !s1_vld_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_valid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
      if (s3_rdy) s3_vld_r <= s2_vld_r;
      if (s4_rdy) s4_vld_r <= s3_vld_r;
    end
  end

  // Stage 1: decay product, current sum and first hash round.
  logic [lif_pkg::IDX_W-1:0]         s1_idx_r;
  logic signed [lif_pkg::DATA_W-1:0] s1_volt_r;
  logic                              s1_live_r;
  logic signed [49:0]                s1_dprod_r;
  logic signed [32:0]                s1_cs_r;
  logic [lif_pkg::DATA_W-1:0]        s1_hash_r;

  logic [lif_pkg::DATA_W-1:0] step_mix, seed_mix, hash_x;
  logic signed [49:0]         dprod_nxt;
  logic signed [32:0]         cs_nxt;
  logic                       live_nxt;

  always_comb begin
    step_mix  = in_time_step * lif_pkg::HASH_STEP_MUL;
    seed_mix  = seed_r * lif_pkg::HASH_SEED_MUL;
    hash_x    = {{(lif_pkg::DATA_W-lif_pkg::IDX_W){1'b0}}, in_neuron_index}
                ^ step_mix ^ seed_mix;
    dprod_nxt = 50'(in_membrane_voltage) * 50'($signed({1'b0, decay_r}));
    cs_nxt    = {in_synaptic_current[31], in_synaptic_current}
                + {in_stimulus_current[31], in_stimulus_current};
    live_nxt  = {9'd0, in_neuron_index} < 25'(lif_pkg::MAX_NEURONS);
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_rdy) begin
      s1_idx_r   <= in_neuron_index;
      s1_volt_r  <= in_membrane_voltage;
      s1_live_r  <= live_nxt;
      s1_dprod_r <= dprod_nxt;
      s1_cs_r    <= cs_nxt;
      s1_hash_r  <= hash_x ^ (hash_x >> 16);
    end
  end

  // Stage 2: hash mix multiply; decayed voltage plus currents.
  logic [lif_pkg::IDX_W-1:0]         s2_idx_r;
  logic signed [lif_pkg::DATA_W-1:0] s2_volt_r;
  logic                              s2_live_r;
  logic signed [35:0]                s2_sum_r;
  logic [lif_pkg::DATA_W-1:0]        s2_hash_r;

  logic signed [33:0] dec_val;

  assign dec_val = s1_dprod_r[49:16];

  always_ff @(posedge clk) begin
    if (s1_vld_r && s2_rdy) begin
      s2_idx_r  <= s1_idx_r;
      s2_volt_r <= s1_volt_r;
      s2_live_r <= s1_live_r;
      s2_sum_r  <= {{2{dec_val[33]}}, dec_val} + {{3{s1_cs_r[32]}}, s1_cs_r};
      s2_hash_r <= s1_hash_r * lif_pkg::HASH_MIX_MUL;
    end
  end

  // Stage 3: noise product. The 16-bit hash minus 32768 is the top bit
  // inverted, read as signed.
  logic [lif_pkg::IDX_W-1:0]         s3_idx_r;
  logic signed [lif_pkg::DATA_W-1:0] s3_volt_r;
  logic                              s3_live_r;
  logic signed [35:0]                s3_sum_r;
  logic signed [47:0]                s3_nprod_r;

  logic [lif_pkg::DATA_W-1:0] hash_fin;
  logic signed [15:0]         rnd;

  always_comb begin
    hash_fin = s2_hash_r ^ (s2_hash_r >> 16);
    rnd      = $signed({~hash_fin[15], hash_fin[14:0]});
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && s3_rdy) begin
      s3_idx_r   <= s2_idx_r;
      s3_volt_r  <= s2_volt_r;
      s3_live_r  <= s2_live_r;
      s3_sum_r   <= s2_sum_r;
      s3_nprod_r <= 48'($signed({1'b0, noise_r})) * 48'(rnd);
    end
  end

  // Stage 4: add noise, compare against threshold, saturate.
  logic signed [32:0] nz_val;
  logic signed [35:0] next_val;
  logic signed [35:0] thresh_ext;
  logic               fire_nxt;
  logic signed [lif_pkg::DATA_W-1:0] volt_nxt;

  always_comb begin
    nz_val     = s3_nprod_r[47:15];
    next_val   = s3_sum_r + {{3{nz_val[32]}}, nz_val};
    thresh_ext = {{4{thresh_r[31]}}, thresh_r};
    fire_nxt   = s3_live_r && (next_val >= thresh_ext);
    if (!s3_live_r) begin
      volt_nxt = s3_volt_r;
    end else if (fire_nxt) begin
      volt_nxt = resetv_r;
    end else if (next_val[35:31] == 5'b00000 || next_val[35:31] == 5'b11111) begin
      volt_nxt = next_val[31:0];
    end else if (next_val[35]) begin
      volt_nxt = {1'b1, {(lif_pkg::DATA_W-1){1'b0}}};
    end else begin
      volt_nxt = {1'b0, {(lif_pkg::DATA_W-1){1'b1}}};
    end
  end

  logic [lif_pkg::IDX_W-1:0]         s4_idx_r;
  logic signed [lif_pkg::DATA_W-1:0] s4_volt_r;
  logic                              s4_fired_r;

  always_ff @(posedge clk) begin
    if (s3_vld_r && s4_rdy) begin
      s4_idx_r   <= s3_idx_r;
      s4_volt_r  <= volt_nxt;
      s4_fired_r <= fire_nxt;
    end
  end

  assign out_valid        = s4_vld_r;
  assign out_neuron_index = s4_idx_r;
  assign out_new_voltage  = s4_volt_r;
  assign out_fired        = s4_fired_r;

endmodule

>>> design/lif_chk.sv
// ----------------------------------------------------------------------------
// LIF neuron update checker
// Port-level assertions on the neuron update pipeline, bound to the top.
// ----------------------------------------------------------------------------
module lif_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic [lif_pkg::IDX_W-1:0]            in_neuron_index,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [lif_pkg::IDX_W-1:0]            out_neuron_index,
  input logic signed [lif_pkg::DATA_W-1:0]    out_new_voltage,
  input logic                                 out_fired
);

  // A result that is not taken holds until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_voltage)
      && $stable(out_fired) && $stable(out_neuron_index))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A ready receiver never stalls the sender.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled with receiver ready");

  // With the receiver ready, each input comes out of the pipeline in order.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid && out_neuron_index == $past(in_neuron_index, 4))
    else $error("result missing or out of order");

endmodule

bind lif_neuron_update lif_chk u_lif_chk (.*);
